>>> rtl/fms_pkg.sv
// Package for the fuzzy match scorer: widths, limits, configuration codes,
// shared types and small character helper functions.
// No dependencies; every other file of the block imports it.
package fms_pkg;

    // Query and text limits.
    localparam int QUERY_CHARS  = 16;
    localparam int QPOS_W       = 5;
    localparam int RUN_W        = 4;
    localparam int SCORE_W      = 12;
    localparam int COUNT_W      = 13;
    localparam int OUT_W        = 11;
    localparam int CHAR_W       = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int PTS_W        = 7;

    localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [OUT_W-1:0]   OUT_MAX   = '1;

    // Scoring constants.
    localparam logic [PTS_W-1:0]   PTS_BASE     = 7'd10;
    localparam logic [PTS_W-1:0]   PTS_BOUNDARY = 7'd20;
    localparam logic [OUT_W-1:0]   SCORE_EXACT  = 11'd1000;
    localparam logic [OUT_W-1:0]   SCORE_EMPTY  = 11'd1;
    localparam logic [OUT_W-1:0]   SCORE_NONE   = 11'd0;
    localparam logic [COUNT_W-1:0] BONUS_END    = 13'd50;

    // Boundary characters.
    localparam logic [CHAR_W-1:0] CH_SLASH     = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UNDERLINE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_DOT       = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_UPPER_A   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_QUERY_LOW    = 2'd0,
        CFG_QUERY_HIGH   = 2'd1,
        CFG_QUERY_LENGTH = 2'd2
    } cfg_index_t;

    // Query as seen by the scoring core.
    typedef struct packed {
        logic [CFG_DATA_W-1:0] chars_low;
        logic [CFG_DATA_W-1:0] chars_high;
        logic [QPOS_W-1:0]     length;
    } query_cfg_t;

    // One registered text item.
    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              text_end;
        logic              no_char;
    } text_item_t;

    // ASCII lower-case fold.
    function automatic logic [CHAR_W-1:0] lower_ascii(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        begin
            r = c;
            if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            begin
                r = c + CASE_OFFSET;
            end
            return r;
        end
    endfunction

    // True for characters that start a new word.
    function automatic logic is_boundary(input logic [CHAR_W-1:0] c);
        return (c == CH_SLASH) || (c == CH_BACKSLASH) || (c == CH_SPACE)
            || (c == CH_UNDERLINE) || (c == CH_DOT);
    endfunction

    // Pick query byte idx out of the two configuration words.
    function automatic logic [CHAR_W-1:0] query_byte(
        input logic [CFG_DATA_W-1:0] low,
        input logic [CFG_DATA_W-1:0] high,
        input logic [3:0]            idx
    );
        logic [CFG_DATA_W-1:0] word;
        begin
            word = idx[3] ? high : low;
            return word[{idx[2:0], 3'b000} +: CHAR_W];
        end
    endfunction

endpackage

>>> rtl/fms_text_if.sv
// Stream interface for text items entering the fuzzy match scorer.
// Depends on fms_pkg for field widths.
interface fms_text_if;
    import fms_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              text_end;
    logic              no_char;

    modport source (output valid, output text_char, output text_end, output no_char,
                    input ready);
    modport sink   (input valid, input text_char, input text_end, input no_char,
                    output ready);
endinterface

>>> rtl/fms_score_if.sv
// Stream interface for scores leaving the fuzzy match scorer.
// Depends on fms_pkg for field widths.
interface fms_score_if;
    import fms_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] match_score;

    modport source (output valid, output match_score, input ready);
    modport sink   (input valid, input match_score, output ready);
endinterface

>>> rtl/fms_cfg_regs.sv
// Configuration registers of the fuzzy match scorer: query bytes and length.
// Depends on fms_pkg; feeds fms_core through a query_cfg_t struct.
module fms_cfg_regs
    import fms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output query_cfg_t             query
);

    logic [CFG_DATA_W-1:0] chars_low_reg;
    logic [CFG_DATA_W-1:0] chars_high_reg;
    logic [QPOS_W-1:0]     length_reg;

    // Register writes; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
            length_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_QUERY_LOW:    chars_low_reg  <= cfg_data;
                CFG_QUERY_HIGH:   chars_high_reg <= cfg_data;
                CFG_QUERY_LENGTH: length_reg     <= cfg_data[QPOS_W-1:0];
                default:          ;
            endcase
        end
    end

    // Lengths above the query capacity are clamped.
    always_comb
    begin
        query.chars_low  = chars_low_reg;
        query.chars_high = chars_high_reg;
        if (length_reg > QPOS_W'(QUERY_CHARS))
        begin
            query.length = QPOS_W'(QUERY_CHARS);
        end
        else
        begin
            query.length = length_reg;
        end
    end

endmodule

>>> rtl/fms_core.sv
// Per-text match state and the combinational scoring step of the fuzzy
// match scorer. Depends on fms_pkg; driven by the input stage of the top level.
module fms_core
    import fms_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  text_item_t       item,
    input  query_cfg_t       query,
    output logic [OUT_W-1:0] score
);

    logic [QPOS_W-1:0]  query_pos_reg,      query_pos_next;
    logic [RUN_W-1:0]   run_length_reg,     run_length_next;
    logic [SCORE_W-1:0] running_score_reg,  running_score_next;
    logic [COUNT_W-1:0] leftover_count_reg, leftover_count_next;
    logic [COUNT_W-1:0] char_index_reg,     char_index_next;
    logic [CHAR_W-1:0]  prev_char_reg,      prev_char_next;
    logic               exact_reg,          exact_next;
    logic               ended_reg,          ended_next;

    // State after taking the character, before an end of text clears it.
    logic [QPOS_W-1:0]  qpos_t;
    logic [RUN_W-1:0]   run_t;
    logic [SCORE_W-1:0] rscore_t;
    logic [COUNT_W-1:0] left_t;
    logic [COUNT_W-1:0] cidx_t;
    logic               exact_t;
    logic               ended_t;

    logic [CHAR_W-1:0]  c;
    logic [CHAR_W-1:0]  q_exact;
    logic [CHAR_W-1:0]  q_next;
    logic [PTS_W-1:0]   pts;
    logic [SCORE_W:0]   score_sum;
    logic [COUNT_W-1:0] with_bonus;
    logic [OUT_W-1:0]   final_s;

    assign c       = item.text_char;
    assign q_exact = query_byte(query.chars_low, query.chars_high, char_index_reg[3:0]);
    assign q_next  = query_byte(query.chars_low, query.chars_high, query_pos_reg[3:0]);

    // Points for a match: base, run bonus and word-start bonus.
    always_comb
    begin
        pts = PTS_BASE + PTS_W'({3'b000, run_length_reg} << 2) + PTS_W'(run_length_reg);
        if (char_index_reg == '0 || is_boundary(prev_char_reg))
        begin
            pts = pts + PTS_BOUNDARY;
        end
        score_sum = {1'b0, running_score_reg} + (SCORE_W+1)'(pts);
    end

    // Take one character into the match state.
    always_comb
    begin
        qpos_t   = query_pos_reg;
        run_t    = run_length_reg;
        rscore_t = running_score_reg;
        left_t   = leftover_count_reg;
        cidx_t   = char_index_reg;
        exact_t  = exact_reg;
        ended_t  = ended_reg;
        if (!item.no_char)
        begin
            if (char_index_reg >= COUNT_W'(query.length) || q_exact != c)
            begin
                exact_t = 1'b0;
            end
            if (query_pos_reg < query.length)
            begin
                if (lower_ascii(c) == lower_ascii(q_next))
                begin
                    rscore_t = score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
                    if (run_length_reg != RUN_MAX)
                    begin
                        run_t = run_length_reg + 1'b1;
                    end
                    qpos_t  = query_pos_reg + 1'b1;
                    ended_t = 1'b1;
                end
                else
                begin
                    run_t   = '0;
                    ended_t = 1'b0;
                end
            end
            else
            begin
                if (leftover_count_reg != COUNT_MAX)
                begin
                    left_t = leftover_count_reg + 1'b1;
                end
                ended_t = 1'b0;
            end
            if (char_index_reg != COUNT_MAX)
            begin
                cidx_t = char_index_reg + 1'b1;
            end
        end
    end

    // Final score of the text from the updated state.
    always_comb
    begin
        with_bonus = COUNT_W'(rscore_t) + BONUS_END;
        final_s    = SCORE_NONE;
        priority if (query.length == '0)
        begin
            final_s = SCORE_EMPTY;
        end
        else if (exact_t && cidx_t == COUNT_W'(query.length))
        begin
            final_s = SCORE_EXACT;
        end
        else if (qpos_t < query.length)
        begin
            final_s = SCORE_NONE;
        end
        else if (ended_t)
        begin
            final_s = (with_bonus > COUNT_W'(OUT_MAX)) ? OUT_MAX : with_bonus[OUT_W-1:0];
        end
        else if (COUNT_W'(rscore_t) > left_t)
        begin
            if (rscore_t - SCORE_W'(left_t) > SCORE_W'(OUT_MAX))
            begin
                final_s = OUT_MAX;
            end
            else
            begin
                final_s = OUT_W'(rscore_t - SCORE_W'(left_t));
            end
        end
        else
        begin
            final_s = SCORE_EMPTY;
        end
    end

    assign score = final_s;

    // Next state: the end of a text returns everything to its reset values.
    always_comb
    begin
        query_pos_next      = query_pos_reg;
        run_length_next     = run_length_reg;
        running_score_next  = running_score_reg;
        leftover_count_next = leftover_count_reg;
        char_index_next     = char_index_reg;
        prev_char_next      = prev_char_reg;
        exact_next          = exact_reg;
        ended_next          = ended_reg;
        if (step)
        begin
            if (item.text_end)
            begin
                query_pos_next      = '0;
                run_length_next     = '0;
                running_score_next  = '0;
                leftover_count_next = '0;
                char_index_next     = '0;
                prev_char_next      = '0;
                exact_next          = 1'b1;
                ended_next          = 1'b0;
            end
            else
            begin
                query_pos_next      = qpos_t;
                run_length_next     = run_t;
                running_score_next  = rscore_t;
                leftover_count_next = left_t;
                char_index_next     = cidx_t;
                prev_char_next      = item.no_char ? prev_char_reg : c;
                exact_next          = exact_t;
                ended_next          = ended_t;
            end
        end
    end

    // Match state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_pos_reg      <= '0;
            run_length_reg     <= '0;
            running_score_reg  <= '0;
            leftover_count_reg <= '0;
            char_index_reg     <= '0;
            prev_char_reg      <= '0;
            exact_reg          <= 1'b1;
            ended_reg          <= 1'b0;
        end
        else
        begin
            query_pos_reg      <= query_pos_next;
            run_length_reg     <= run_length_next;
            running_score_reg  <= running_score_next;
            leftover_count_reg <= leftover_count_next;
            char_index_reg     <= char_index_next;
            prev_char_reg      <= prev_char_next;
            exact_reg          <= exact_next;
            ended_reg          <= ended_next;
        end
    end

`ifndef SYNTHESIS
    // A finished text leaves the match state cleared.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.text_end |=> query_pos_reg == '0 && exact_reg && char_index_reg == '0)
        else $error("match state not cleared after end of text");

    // A run of consecutive matches never exceeds the matched query characters.
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        COUNT_W'(run_length_reg) <= COUNT_W'(query_pos_reg))
        else $error("run length exceeds query position");

    // Ending on a match requires at least one matched character.
    a_ended_pos: assert property (@(posedge clk) disable iff (!rst_n)
        ended_reg |-> query_pos_reg != '0)
        else $error("ended on match with no matched character");

    // The state holds when no item is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(query_pos_reg) && $stable(char_index_reg)
                  && $stable(running_score_reg))
        else $error("match state changed without an item");
`endif

endmodule

>>> rtl/fuzzy_match_scorer.sv
// Top level of the fuzzy match scorer: input register, scoring core and
// result register. Depends on fms_pkg, fms_text_if, fms_score_if, fms_cfg_regs, fms_core.
//
//   Channel    Dir  Transfer payload                   Notes
//   text_in    in   text_char, text_end, no_char       one character per transfer
//   score_out  out  match_score                        one transfer per ended text
//   cfg_*      in   cfg_index, cfg_data on cfg_we      write only, no wait
//
// One item per cycle sustained while score_out does not stall; the item that ends
// a text passes the input register, then its score the result register.
// The scoring step is one pass of compare and small add logic in fms_core.
// Reset (rst_n low, asynchronous) clears the query, the match state and both valids.
// A held result stalls the input register, which stalls text_in only when full.
module fuzzy_match_scorer
    import fms_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    fms_text_if.sink               text_in,
    fms_score_if.source            score_out,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    query_cfg_t       query;
    text_item_t       item_reg;
    logic             item_valid_reg;
    logic [OUT_W-1:0] score_reg;
    logic             score_valid_reg;
    logic [OUT_W-1:0] core_score;
    logic             advance;
    logic             step;

    fms_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .query     (query)
    );

    fms_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (item_reg),
        .query (query),
        .score (core_score)
    );

    // The stage advances whenever the result register is free or being taken.
    assign advance       = !score_valid_reg || score_out.ready;
    assign step          = item_valid_reg && advance;
    assign text_in.ready = !item_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (text_in.ready)
        begin
            item_valid_reg <= text_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (text_in.ready && text_in.valid)
        begin
            item_reg.text_char <= text_in.text_char;
            item_reg.text_end  <= text_in.text_end;
            item_reg.no_char   <= text_in.no_char;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            score_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            score_valid_reg <= step && item_reg.text_end;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && item_reg.text_end)
        begin
            score_reg <= core_score;
        end
    end

    assign score_out.valid       = score_valid_reg;
    assign score_out.match_score = score_reg;

`ifndef SYNTHESIS
    // A new score only comes from an item that ended a text.
    a_score_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(score_valid_reg) |-> $past(step && item_reg.text_end))
        else $error("score produced without an end of text");

    // A stalled input register keeps its item.
    a_item_hold: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !advance |=> item_valid_reg && $stable(item_reg))
        else $error("stalled item lost or changed");

    // The input side is only blocked by a full input register behind a held result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !text_in.ready |-> item_valid_reg && score_valid_reg)
        else $error("input blocked without a stall");
`endif

endmodule

>>> tb/sv/tb_fuzzy_match_scorer.sv
// Self-checking testbench for fuzzy_match_scorer: streams candidate texts, scores
// each finished text in a behavioral model of its own and checks every score transfer.
// Depends on fms_pkg, fms_text_if, fms_score_if and the scorer RTL.
module tb_fuzzy_match_scorer;
    import fms_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 440;
    localparam int SETTLE_CYCLES = 6;
    localparam int LONG_FILL     = 40;
    localparam int MAX_REPORTS   = 10;

    typedef logic [CHAR_W-1:0] char_q_t[$];

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    fms_text_if  text_if ();
    fms_score_if score_if ();

    fuzzy_match_scorer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_if),
        .score_out (score_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Query as last written, and the per-text match state of the model.
    logic [CFG_DATA_W-1:0] qry_low;
    logic [CFG_DATA_W-1:0] qry_high;
    logic [QPOS_W-1:0]     qry_len;
    logic [QPOS_W-1:0]     exp_pos;
    logic [RUN_W-1:0]      exp_run;
    logic [SCORE_W-1:0]    exp_total;
    logic [COUNT_W-1:0]    exp_leftover;
    logic [COUNT_W-1:0]    exp_index;
    logic [CHAR_W-1:0]     exp_prev;
    logic                  exp_exact;
    logic                  exp_on_match;

    // Scores of finished texts that have not come out yet, oldest first.
    logic [OUT_W-1:0] pending_scores[$];

    int fail_count = 0;
    int text_items = 0;
    bit text_idling = 1'b1;
    bit score_stalling = 1'b1;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #(4_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Scoring model
    // ------------------------------------------------------------------

    function automatic int used_length();
        return (qry_len > QUERY_CHARS) ? QUERY_CHARS : int'(qry_len);
    endfunction

    function automatic logic [CHAR_W-1:0] query_char_at(int pos);
        logic [CFG_DATA_W-1:0] word;
        word = (pos % 16 < 8) ? qry_low : qry_high;
        return word[(pos % 8) * 8 +: 8];
    endfunction

    function automatic logic [CHAR_W-1:0] fold_case(logic [CHAR_W-1:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] flip_case(logic [CHAR_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            return c + 8'h20;
        end
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            return c - 8'h20;
        end
        return c;
    endfunction

    function automatic bit starts_word(logic [CHAR_W-1:0] c);
        return c == CH_SLASH || c == CH_BACKSLASH || c == CH_SPACE
            || c == CH_UNDERLINE || c == CH_DOT;
    endfunction

    function automatic void clear_match_state();
        exp_pos      = '0;
        exp_run      = '0;
        exp_total    = '0;
        exp_leftover = '0;
        exp_index    = '0;
        exp_prev     = '0;
        exp_exact    = 1'b1;
        exp_on_match = 1'b0;
    endfunction

    // One character of the text: greedy in-order match with run and word-start bonuses.
    function automatic void take_text_char(logic [CHAR_W-1:0] c);
        int len;
        int pts;
        int total;
        len = used_length();
        if (exp_index >= len || query_char_at(exp_index) != c)
        begin
            exp_exact = 1'b0;
        end
        if (exp_pos < len)
        begin
            if (fold_case(c) == fold_case(query_char_at(exp_pos)))
            begin
                pts = 10 + 5 * int'(exp_run);
                if (exp_index == 0 || starts_word(exp_prev))
                begin
                    pts += 20;
                end
                total = int'(exp_total) + pts;
                exp_total = (total > int'(SCORE_MAX)) ? SCORE_MAX : total[SCORE_W-1:0];
                if (exp_run != RUN_MAX)
                begin
                    exp_run++;
                end
                exp_pos++;
                exp_on_match = 1'b1;
            end
            else
            begin
                exp_run = '0;
                exp_on_match = 1'b0;
            end
        end
        else
        begin
            if (exp_leftover != COUNT_MAX)
            begin
                exp_leftover++;
            end
            exp_on_match = 1'b0;
        end
        if (exp_index != COUNT_MAX)
        begin
            exp_index++;
        end
        exp_prev = c;
    endfunction

    // Score of the text seen so far, as given when the text ends.
    function automatic int finished_score();
        int len;
        int s;
        len = used_length();
        if (len == 0)
        begin
            return 1;
        end
        if (exp_exact && exp_index == len)
        begin
            return 1000;
        end
        if (exp_pos < len)
        begin
            return 0;
        end
        if (exp_on_match)
        begin
            s = int'(exp_total) + 50;
        end
        else
        begin
            s = (exp_total > exp_leftover) ? int'(exp_total) - int'(exp_leftover) : 0;
        end
        if (s < 1)
        begin
            s = 1;
        end
        if (s > int'(OUT_MAX))
        begin
            s = int'(OUT_MAX);
        end
        return s;
    endfunction

    function automatic void predict_item(logic [CHAR_W-1:0] c, bit last, bit empty);
        if (!empty)
        begin
            take_text_char(c);
        end
        if (last)
        begin
            pending_scores.push_back(OUT_W'(finished_score()));
            clear_match_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap(bit enabled);
        int r;
        if (!enabled)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Letters of both cases, word separators, digits and now and then any byte.
    function automatic logic [CHAR_W-1:0] random_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return CHAR_W'(8'h61 + $urandom_range(0, 25));
        end
        if (r < 65)
        begin
            return CHAR_W'(8'h41 + $urandom_range(0, 25));
        end
        if (r < 80)
        begin
            case ($urandom_range(0, 4))
                0:       return CH_SLASH;
                1:       return CH_BACKSLASH;
                2:       return CH_SPACE;
                3:       return CH_UNDERLINE;
                default: return CH_DOT;
            endcase
        end
        if (r < 90)
        begin
            return CHAR_W'(8'h30 + $urandom_range(0, 9));
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    function automatic char_q_t chars_of(string s);
        char_q_t q;
        for (int i = 0; i < s.len(); i++)
        begin
            q.push_back(s[i]);
        end
        return q;
    endfunction

    // Random text, mostly built around the current query so that matching goes deep.
    function automatic char_q_t make_text();
        char_q_t t;
        int len;
        int kind;
        int keep;
        int pick;
        logic [CHAR_W-1:0] c;
        len = used_length();
        kind = $urandom_range(0, 9);
        if (kind == 7)
        begin
            repeat ($urandom_range(0, 12)) t.push_back(random_char());
        end
        else if (kind == 0 || kind == 9)
        begin
            // Exact copy of the query, or a copy with one character spoiled.
            for (int i = 0; i < len; i++)
            begin
                t.push_back(query_char_at(i));
            end
            if (kind == 9 && t.size() > 0)
            begin
                if ($urandom_range(0, 1))
                begin
                    pick = $urandom_range(0, t.size() - 1);
                    c = flip_case(t[pick]);
                    t[pick] = (c == t[pick]) ? c ^ 8'h01 : c;
                end
                else
                begin
                    void'(t.pop_back());
                end
            end
        end
        else if (kind != 8)
        begin
            // Query characters in order with fillers between; a prefix only for kind 6.
            keep = (kind == 6) ? $urandom_range(0, len) : len;
            for (int i = 0; i < keep; i++)
            begin
                repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0)
                    t.push_back(random_char());
                c = query_char_at(i);
                t.push_back($urandom_range(0, 1) ? flip_case(c) : c);
            end
            if ($urandom_range(0, 1))
            begin
                repeat ($urandom_range(1, 4)) t.push_back(random_char());
            end
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Channel and register tasks
    // ------------------------------------------------------------------

    // One text item: optional idle, then hold valid until the transfer.
    task automatic send_item(logic [CHAR_W-1:0] c, bit last, bit empty);
        int gap;
        gap = pick_gap(text_idling);
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid     <= 1'b1;
        text_if.text_char <= c;
        text_if.text_end  <= last;
        text_if.no_char   <= empty;
        do
        begin
            @(posedge clk);
        end
        while (!text_if.ready);
        text_items++;
        predict_item(c, last, empty);
    endtask

    // A whole text; it ends on its last character or on a separate empty item.
    task automatic send_text(input char_q_t chars, input bit tail_marker, input bit sprinkle);
        for (int i = 0; i < chars.size(); i++)
        begin
            if (sprinkle && $urandom_range(0, 11) == 0)
            begin
                send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
            end
            send_item(chars[i], (i == chars.size() - 1) && !tail_marker, 1'b0);
        end
        if (tail_marker || chars.size() == 0)
        begin
            send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
    endtask

    // Stop sending and wait until every pending score has been transferred.
    task automatic drain_scores();
        text_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_scores.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_QUERY_LOW:    qry_low  = value;
            CFG_QUERY_HIGH:   qry_high = value;
            CFG_QUERY_LENGTH: qry_len  = value[QPOS_W-1:0];
            default:          ;
        endcase
        @(posedge clk);
    endtask

    // Load a query string; bytes past the string are random.
    task automatic set_query(string s, int len);
        logic [CFG_DATA_W-1:0] low;
        logic [CFG_DATA_W-1:0] high;
        drain_scores();
        low  = {$urandom, $urandom};
        high = {$urandom, $urandom};
        for (int i = 0; i < s.len(); i++)
        begin
            if (i < 8)
            begin
                low[i * 8 +: 8] = s[i];
            end
            else
            begin
                high[(i - 8) * 8 +: 8] = s[i];
            end
        end
        write_reg(CFG_QUERY_LOW, low);
        write_reg(CFG_QUERY_HIGH, high);
        write_reg(CFG_QUERY_LENGTH, CFG_DATA_W'(len));
    endtask

    // Random query: structured or raw words, lengths from empty to beyond the limit.
    task automatic pick_config();
        logic [CFG_DATA_W-1:0] word;
        int len;
        drain_scores();
        for (int w = 0; w < 2; w++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                word = {$urandom, $urandom};
            end
            else
            begin
                for (int b = 0; b < 8; b++)
                begin
                    word[b * 8 +: 8] = random_char();
                end
            end
            write_reg(w == 0 ? CFG_QUERY_LOW : CFG_QUERY_HIGH, word);
        end
        case ($urandom_range(0, 9))
            0:       len = 0;
            1:       len = QUERY_CHARS;
            2:       len = 31;
            3:       len = $urandom_range(17, 30);
            default: len = $urandom_range(1, 15);
        endcase
        write_reg(CFG_QUERY_LENGTH, CFG_DATA_W'(len));
    endtask

    // ------------------------------------------------------------------
    // Score side: random back-pressure and checking
    // ------------------------------------------------------------------

    initial
    begin
        int stall_left;
        stall_left = 0;
        score_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 299) == 0)
            begin
                score_stalling = !score_stalling;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                score_if.ready <= 1'b0;
            end
            else
            begin
                score_if.ready <= 1'b1;
                stall_left = pick_gap(score_stalling);
            end
        end
    end

    task automatic check_score(logic [OUT_W-1:0] got);
        logic [OUT_W-1:0] want;
        if (pending_scores.size() == 0)
        begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
            begin
                $display("%0t: match_score %0d transferred with no text pending", $time, got);
            end
        end
        else
        begin
            want = pending_scores.pop_front();
            if (got !== want)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                begin
                    $display("%0t: match_score expected %0d, got %0d", $time, want, got);
                end
            end
        end
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && score_if.valid && score_if.ready)
            begin
                check_score(score_if.match_score);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty query after reset: every text scores 1, an empty text too.
    task automatic test_empty_query();
        send_text(chars_of("x"), 1'b0, 1'b0);
        send_text(chars_of(""), 1'b0, 1'b0);
    endtask

    // Exact match with an ignored empty item inside, case difference, incomplete match.
    task automatic test_exact_and_case();
        set_query("abc", 3);
        send_item("a", 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item("b", 1'b0, 1'b0);
        send_item("c", 1'b1, 1'b0);
        send_text(chars_of("aBc"), 1'b0, 1'b0);
        send_text(chars_of("ab"), 1'b0, 1'b0);
    endtask

    // Word-start bonus after each separator; leftover characters after the last match.
    task automatic test_boundaries();
        send_text(chars_of("/a\\b c"), 1'b0, 1'b0);
        send_text(chars_of("_a.bcz"), 1'b1, 1'b0);
    endtask

    // Zero bytes are ordinary characters; a length above the limit is clamped.
    task automatic test_zero_and_clamp();
        char_q_t t;
        drain_scores();
        write_reg(CFG_QUERY_LOW, {$urandom, 16'(~$urandom), 8'h61, 8'h00});
        write_reg(CFG_QUERY_LENGTH, CFG_DATA_W'(2));
        t = {8'h00, 8'h41};
        send_text(t, 1'b0, 1'b0);
        drain_scores();
        write_reg(CFG_QUERY_LENGTH, CFG_DATA_W'(31));
        send_text(t, 1'b0, 1'b0);
    endtask

    // Back-to-back texts with a long filler before the match and a long leftover tail.
    task automatic test_long_texts();
        char_q_t t;
        bit saved_idling;
        set_query("ab", 2);
        saved_idling = text_idling;
        text_idling = 1'b0;
        repeat (LONG_FILL) t.push_back("z");
        t.push_back("a");
        t.push_back("b");
        send_text(t, 1'b0, 1'b0);
        t = {"a", "b"};
        repeat (LONG_FILL) t.push_back("x");
        send_text(t, 1'b0, 1'b0);
        text_idling = saved_idling;
    endtask

    // Phases of random queries, each followed by a batch of random texts.
    task automatic test_random_texts();
        int start_items;
        int batch;
        start_items = text_items;
        while (text_items - start_items < RANDOM_ITEMS)
        begin
            pick_config();
            batch = $urandom_range(4, 12);
            while (batch > 0 && text_items - start_items < RANDOM_ITEMS)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    text_idling = !text_idling;
                end
                send_text(make_text(), $urandom_range(0, 3) == 0, 1'b1);
                batch--;
            end
        end
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_QUERY_LOW;
        cfg_data          <= '0;
        text_if.valid     <= 1'b0;
        text_if.text_char <= '0;
        text_if.text_end  <= 1'b0;
        text_if.no_char   <= 1'b0;
        qry_low  = '0;
        qry_high = '0;
        qry_len  = '0;
        clear_match_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_query();
        test_exact_and_case();
        test_boundaries();
        test_zero_and_clamp();
        test_long_texts();
        test_random_texts();

        drain_scores();
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
